// ----- design/ppt_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants of the point-in-polygon test.
// Used by every design file through scoped names; depends on nothing.

package ppt_pkg;

  localparam int MAX_VERTICES = 64;
  localparam int VADDR_W      = $clog2(MAX_VERTICES);
  localparam int CNT_W        = $clog2(MAX_VERTICES + 1);

  localparam int COORD_W      = 16;
  localparam int IDX_W        = 6;
  localparam int COUNT_W      = 7;
  localparam int DIFF_W       = COORD_W + 1;
  localparam int PROD_W       = 2 * COORD_W + 1;
  localparam int MAG_W        = 2 * COORD_W;
  localparam int DEN_MAG_W    = COORD_W;
  localparam int QUO_W        = MAG_W + 1;
  localparam int CROSS_W      = QUO_W + 1;
  localparam int VERT_W       = 2 * COORD_W;

  localparam int DIV_STEPS    = MAG_W;
  localparam int DIV_CNT_W    = $clog2(DIV_STEPS);

  localparam int APB_ADDR_W   = 3;
  localparam int APB_DATA_W   = 32;

  localparam logic REG_VERTEX_COUNT = 1'b0;

  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREV,
    ST_CUR,
    ST_TEST,
    ST_DIVGO,
    ST_DIV,
    ST_NEXT,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic                     start;
    logic signed [PROD_W-1:0] dividend;
    logic signed [DIFF_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic                    done;
    logic signed [QUO_W-1:0] quotient;
  } div_rsp_t;

endpackage

// ----- design/point_in_polygon_test.sv -----
`timescale 1ns / 1ps
// Top level of the even-odd point-in-polygon test.
// Depends on ppt_pkg, ppt_vertex_mem and ppt_div.
//
// Usage:
//   Input channel (in_valid/in_ready): mode 0 stores a vertex at vertex_index,
//   mode 1 queries the point (coord_x, coord_y). Output channel
//   (out_valid/out_ready) carries one inside_res per query; writes give none.
//   The APB port holds vertex_count at address 0; counts above the store depth
//   saturate. Write it only while the block is idle.
//   A query walks the edges in order; an edge that straddles the query y runs
//   the serial divider (one quotient bit per cycle, 32 bits), which sets the
//   cost of a straddling edge, and the single vertex memory read port sets one
//   read per edge. A query with vertex_count zero skips the edge walk. One item
//   is in work at a time.
//   The result sits in an output register; the next item is accepted while
//   it waits. A query that finishes while the receiver stalls holds until
//   the register frees.
//   Reset (synchronous, rst_n low) clears vertex_count, the control and the
//   output valid. Vertex contents are undefined until written.

module point_in_polygon_test (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            in_mode,
  input  logic [ppt_pkg::IDX_W-1:0]       in_vertex_index,
  input  logic signed [ppt_pkg::COORD_W-1:0] in_coord_x,
  input  logic signed [ppt_pkg::COORD_W-1:0] in_coord_y,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            out_inside_res,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [ppt_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [ppt_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [ppt_pkg::APB_DATA_W-1:0]  prdata,
  output logic                            pready
);

  ppt_pkg::state_t state_r, state_nxt;

  logic [ppt_pkg::COUNT_W-1:0]         count_r;
  logic [ppt_pkg::CNT_W-1:0]           n_r;
  logic [ppt_pkg::CNT_W-1:0]           idx_r;
  logic                                flag_r;
  logic signed [ppt_pkg::COORD_W-1:0]  qx_r, qy_r;
  logic signed [ppt_pkg::COORD_W-1:0]  prev_x_r, prev_y_r, cur_x_r, cur_y_r;
  logic signed [ppt_pkg::PROD_W-1:0]   prod_r;
  logic signed [ppt_pkg::DIFF_W-1:0]   den_r;
  logic                                out_valid_r;
  logic                                out_inside_r;

  logic [ppt_pkg::CNT_W-1:0]           n_sat;
  logic                                slot_ok;
  logic                                accept;
  logic                                is_last;
  logic                                straddle;
  logic                                crosses;
  logic                                out_free;
  logic signed [ppt_pkg::DIFF_W-1:0]   dx, dyq, den;
  logic signed [2*ppt_pkg::DIFF_W-1:0] prod_full;
  logic signed [ppt_pkg::CROSS_W-1:0]  cross_x;

  logic                                mem_wr_en;
  logic                                mem_rd_en;
  logic [ppt_pkg::VADDR_W-1:0]         mem_rd_addr;
  logic [ppt_pkg::VERT_W-1:0]          mem_rd_data;
  logic                                load_prev, load_cur, load_mul, advance, load_out;
  logic                                div_start;

  ppt_pkg::div_req_t                   div_req;
  ppt_pkg::div_rsp_t                   div_rsp;

  assign pready  = 1'b1;
  assign prdata  = (paddr[2] == ppt_pkg::REG_VERTEX_COUNT)
                   ? ppt_pkg::APB_DATA_W'(count_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (psel && penable && pwrite && pready
                 && paddr[2] == ppt_pkg::REG_VERTEX_COUNT) begin
      count_r <= pwdata[ppt_pkg::COUNT_W-1:0];
    end
  end

  assign n_sat    = (32'(count_r) > ppt_pkg::MAX_VERTICES)
                    ? ppt_pkg::CNT_W'(ppt_pkg::MAX_VERTICES)
                    : ppt_pkg::CNT_W'(count_r);
  assign slot_ok  = 32'(in_vertex_index) < ppt_pkg::MAX_VERTICES;
  assign accept   = in_valid && in_ready;
  assign is_last  = idx_r == (n_r - ppt_pkg::CNT_W'(1));
  assign out_free = !out_valid_r || out_ready;

  assign straddle  = (cur_y_r > qy_r) != (prev_y_r > qy_r);
  assign dx        = ppt_pkg::DIFF_W'(prev_x_r) - ppt_pkg::DIFF_W'(cur_x_r);
  assign dyq       = ppt_pkg::DIFF_W'(qy_r) - ppt_pkg::DIFF_W'(cur_y_r);
  assign den       = ppt_pkg::DIFF_W'(prev_y_r) - ppt_pkg::DIFF_W'(cur_y_r);
  assign prod_full = dx * dyq;
  assign cross_x   = ppt_pkg::CROSS_W'(div_rsp.quotient) + ppt_pkg::CROSS_W'(cur_x_r);
  assign crosses   = ppt_pkg::CROSS_W'(qx_r) < cross_x;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ppt_pkg::ST_IDLE: begin
        if (in_valid && in_mode == ppt_pkg::MODE_QUERY) begin
          state_nxt = (n_sat == '0) ? ppt_pkg::ST_DONE : ppt_pkg::ST_PREV;
        end
      end
      ppt_pkg::ST_PREV:  state_nxt = ppt_pkg::ST_CUR;
      ppt_pkg::ST_CUR:   state_nxt = ppt_pkg::ST_TEST;
      ppt_pkg::ST_TEST:  state_nxt = straddle ? ppt_pkg::ST_DIVGO : ppt_pkg::ST_NEXT;
      ppt_pkg::ST_DIVGO: state_nxt = ppt_pkg::ST_DIV;
      ppt_pkg::ST_DIV: begin
        if (div_rsp.done) begin
          state_nxt = ppt_pkg::ST_NEXT;
        end
      end
      ppt_pkg::ST_NEXT:  state_nxt = is_last ? ppt_pkg::ST_DONE : ppt_pkg::ST_CUR;
      ppt_pkg::ST_DONE: begin
        if (out_free) begin
          state_nxt = ppt_pkg::ST_IDLE;
        end
      end
      default:           state_nxt = ppt_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready    = 1'b0;
    mem_rd_en   = 1'b0;
    mem_rd_addr = idx_r[ppt_pkg::VADDR_W-1:0];
    load_prev   = 1'b0;
    load_cur    = 1'b0;
    load_mul    = 1'b0;
    div_start   = 1'b0;
    advance     = 1'b0;
    load_out    = 1'b0;
    case (state_r)
      ppt_pkg::ST_IDLE: begin
        in_ready    = 1'b1;
        mem_rd_en   = in_valid && in_mode == ppt_pkg::MODE_QUERY;
        mem_rd_addr = ppt_pkg::VADDR_W'(n_sat - ppt_pkg::CNT_W'(1));
      end
      ppt_pkg::ST_PREV: begin
        load_prev = 1'b1;
        mem_rd_en = 1'b1;
      end
      ppt_pkg::ST_CUR:   load_cur  = 1'b1;
      ppt_pkg::ST_TEST:  load_mul  = straddle;
      ppt_pkg::ST_DIVGO: div_start = 1'b1;
      ppt_pkg::ST_DIV:   ;
      ppt_pkg::ST_NEXT: begin
        advance     = 1'b1;
        mem_rd_en   = !is_last;
        mem_rd_addr = ppt_pkg::VADDR_W'(idx_r + ppt_pkg::CNT_W'(1));
      end
      ppt_pkg::ST_DONE:  load_out  = out_free;
      default:           ;
    endcase
  end

  assign mem_wr_en = accept && in_mode == ppt_pkg::MODE_WRITE && slot_ok;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ppt_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && in_mode == ppt_pkg::MODE_QUERY) begin
      n_r    <= n_sat;
      idx_r  <= '0;
      flag_r <= 1'b0;
      qx_r   <= in_coord_x;
      qy_r   <= in_coord_y;
    end
    if (load_prev) begin
      prev_x_r <= mem_rd_data[ppt_pkg::VERT_W-1:ppt_pkg::COORD_W];
      prev_y_r <= mem_rd_data[ppt_pkg::COORD_W-1:0];
    end
    if (load_cur) begin
      cur_x_r <= mem_rd_data[ppt_pkg::VERT_W-1:ppt_pkg::COORD_W];
      cur_y_r <= mem_rd_data[ppt_pkg::COORD_W-1:0];
    end
    if (load_mul) begin
      prod_r <= prod_full[ppt_pkg::PROD_W-1:0];
      den_r  <= den;
    end
    if (state_r == ppt_pkg::ST_DIV && div_rsp.done && crosses) begin
      flag_r <= !flag_r;
    end
    if (advance) begin
      prev_x_r <= cur_x_r;
      prev_y_r <= cur_y_r;
      idx_r    <= idx_r + ppt_pkg::CNT_W'(1);
    end
    if (load_out) begin
      out_inside_r <= flag_r;
    end
  end

  assign div_req.start    = div_start;
  assign div_req.dividend = prod_r;
  assign div_req.divisor  = den_r;

  ppt_vertex_mem u_mem (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (ppt_pkg::VADDR_W'(in_vertex_index)),
    .wr_data ({in_coord_x, in_coord_y}),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  ppt_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign out_valid      = out_valid_r;
  assign out_inside_res = out_inside_r;

endmodule

// ----- design/ppt_vertex_mem.sv -----
`timescale 1ns / 1ps
// Vertex store: one synchronous memory of packed (x, y) pairs, read data registered.
// Depends on ppt_pkg for depth and widths.

module ppt_vertex_mem (
  input  logic                        clk,
  input  logic                        wr_en,
  input  logic [ppt_pkg::VADDR_W-1:0] wr_addr,
  input  logic [ppt_pkg::VERT_W-1:0]  wr_data,
  input  logic                        rd_en,
  input  logic [ppt_pkg::VADDR_W-1:0] rd_addr,
  output logic [ppt_pkg::VERT_W-1:0]  rd_data
);

  logic [ppt_pkg::VERT_W-1:0] mem [ppt_pkg::MAX_VERTICES];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- design/ppt_div.sv -----
`timescale 1ns / 1ps
// Serial signed divider, one quotient bit per cycle, truncating toward zero.
// Depends on ppt_pkg for the request and response structs.

module ppt_div (
  input  logic              clk,
  input  logic              rst_n,
  input  ppt_pkg::div_req_t req,
  output ppt_pkg::div_rsp_t rsp
);

  logic                            busy_r;
  logic                            done_r;
  logic [ppt_pkg::DIV_CNT_W-1:0]   cnt_r;
  logic [ppt_pkg::MAG_W-1:0]       dvd_r;
  logic [ppt_pkg::DEN_MAG_W-1:0]   rem_r;
  logic [ppt_pkg::DEN_MAG_W-1:0]   dsr_r;
  logic                            neg_r;

  logic                            neg_a;
  logic                            neg_b;
  logic [ppt_pkg::PROD_W-1:0]      a_abs;
  logic [ppt_pkg::DIFF_W-1:0]      b_abs;
  logic [ppt_pkg::DEN_MAG_W:0]     sh;
  logic [ppt_pkg::DEN_MAG_W:0]     diff;
  logic                            ge;
  logic [ppt_pkg::DEN_MAG_W-1:0]   rem_step;
  logic [ppt_pkg::QUO_W-1:0]       quo_mag;

  assign neg_a    = req.dividend[ppt_pkg::PROD_W-1];
  assign neg_b    = req.divisor[ppt_pkg::DIFF_W-1];
  assign a_abs    = neg_a ? (~req.dividend + 1'b1) : req.dividend;
  assign b_abs    = neg_b ? (~req.divisor + 1'b1) : req.divisor;

  assign sh       = {rem_r, dvd_r[ppt_pkg::MAG_W-1]};
  assign ge       = sh >= {1'b0, dsr_r};
  assign diff     = sh - {1'b0, dsr_r};
  assign rem_step = ge ? diff[ppt_pkg::DEN_MAG_W-1:0] : sh[ppt_pkg::DEN_MAG_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == ppt_pkg::DIV_CNT_W'(ppt_pkg::DIV_STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      dvd_r <= a_abs[ppt_pkg::MAG_W-1:0];
      rem_r <= '0;
      dsr_r <= b_abs[ppt_pkg::DEN_MAG_W-1:0];
      neg_r <= neg_a ^ neg_b;
    end else if (busy_r) begin
      dvd_r <= {dvd_r[ppt_pkg::MAG_W-2:0], ge};
      rem_r <= rem_step;
    end
  end

  assign quo_mag      = {1'b0, dvd_r};
  assign rsp.done     = done_r;
  assign rsp.quotient = neg_r ? (~quo_mag + 1'b1) : quo_mag;

endmodule

// ----- design/ppt_checker.sv -----
`timescale 1ns / 1ps
// Port-level checks of the point-in-polygon test, bound to the top level.
// Depends on ppt_pkg for the mode codes.

module ppt_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic in_mode,
  input logic out_valid,
  input logic out_ready,
  input logic out_inside_res
);

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_inside_res))
    else $error("stalled result changed or dropped");

  // drop input readiness once a query is taken
  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_mode == ppt_pkg::MODE_QUERY |=> !in_ready)
    else $error("input taken during a query");

  // a vertex transfer never raises a result
  a_write_silent: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_mode == ppt_pkg::MODE_WRITE |=> !$rose(out_valid))
    else $error("result after a vertex write");

  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind point_in_polygon_test ppt_checker u_ppt_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_ready       (in_ready),
  .in_mode        (in_mode),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_inside_res (out_inside_res)
);
